@@ src/pci_config_device_search_macros.svh @@
// Assertion helpers shared by the search engine.
`ifndef PCI_CONFIG_DEVICE_SEARCH_MACROS_SVH
`define PCI_CONFIG_DEVICE_SEARCH_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define PCIDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define PCIDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pcids_pkg.sv @@
`default_nettype none

package pcids_pkg;

    // Number of buses scanned (1 to 256).
    localparam int unsigned BUS_COUNT = 256;
    localparam logic [8:0]  BUS_LIMIT = 9'(BUS_COUNT);

    localparam logic [4:0]  LAST_SLOT     = 5'd31;
    localparam logic [2:0]  LAST_FUNCTION = 3'd7;
    localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;

    // Config space dword offsets.
    localparam logic [7:0] OFF_ID          = 8'h00;
    localparam logic [7:0] OFF_CLASS       = 8'h08;
    localparam logic [7:0] OFF_HEADER      = 8'h0C;
    localparam logic [7:0] OFF_DWORD_MASK  = 8'hFC;

    // Opcodes of the input word.
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_REQUEST   = 2'd0;
    localparam logic [1:0] KIND_FOUND     = 2'd1;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd2;
    localparam logic [1:0] KIND_IGNORED   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PROBE     = 3'd1,
        PH_HEADER    = 3'd2,
        PH_FUNC_ID   = 3'd3,
        PH_CLASS     = 3'd4,
        PH_FOUND_HDR = 3'd5
    } t_phase;

    typedef struct packed {
        logic        opcode;
        logic [15:0] vendor_key;
        logic [15:0] device_key;
        logic [31:0] read_data;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] request_address;
        logic [7:0]  bus_number;
        logic [4:0]  slot_number;
        logic [2:0]  function_number;
        logic [7:0]  base_class;
        logic [7:0]  subclass_code;
        logic [7:0]  programming_interface;
        logic [7:0]  revision;
        logic [7:0]  header_kind;
    } t_out_word;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  cur_bus;
        logic [4:0]  cur_slot;
        logic [2:0]  cur_function;
        logic        multi_function;
        logic [15:0] want_vendor;
        logic [15:0] want_device;
        logic [31:0] class_word;
    } t_search_state;

endpackage

`default_nettype wire

@@ src/pci_config_device_search.sv @@
// PCI config mechanism 1 device search: one result word per input word.
// Path: each accepted word goes to the input register, then through the
// search logic into the result register.
// Throughput: one word per cycle; input stalls only while both registers are
// full and the result word waits. Reset (i_rst_n low, synchronous): search
// idle, location and keys cleared, both pipeline registers empty.
`default_nettype none
`include "pci_config_device_search_macros.svh"

module pci_config_device_search
    import pcids_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    // Input register: holds one word until the search step consumes it.
    logic          r_in_valid;
    t_in_word      r_in_word;

    // Result register.
    logic          r_out_valid;
    t_out_word     r_out_word;

    t_search_state w_state;
    t_search_state w_state_next;
    t_out_word     w_result;
    logic          w_advance;

    // The step fires when a word waits and the result slot is free or
    // being drained this cycle; the search state moves with it.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    pcids_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_advance),
        .i_next   (w_state_next),
        .o_state  (w_state)
    );

    // Decides the next request, or reports found / not found / ignored.
    pcids_step u_step (
        .i_state  (w_state),
        .i_word   (r_in_word),
        .o_state  (w_state_next),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks
    `PCIDS_ASSERT_NOW(a_req_enable, i_clk, i_rst_n,
        r_out_valid && (r_out_word.kind == KIND_REQUEST),
        r_out_word.request_address[31], "request without enable bit")
    `PCIDS_ASSERT_NOW(a_addr_zero, i_clk, i_rst_n,
        r_out_valid && (r_out_word.kind != KIND_REQUEST),
        r_out_word.request_address == 32'd0, "address set on non-request word")
    `PCIDS_ASSERT_NEXT(a_found_idle, i_clk, i_rst_n,
        w_advance && (w_result.kind == KIND_FOUND),
        w_state.phase == PH_IDLE, "search not idle after found")
    `PCIDS_ASSERT_NOW(a_stall_full, i_clk, i_rst_n,
        !o_in_ready,
        r_in_valid && r_out_valid, "input stalled with free stage")

endmodule

`default_nettype wire

@@ src/pcids_state.sv @@
`default_nettype none

module pcids_state
    import pcids_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_update,
    input  wire t_search_state i_next,
    output t_search_state      o_state
);

    t_search_state r_state;

    // All-zero state is the idle phase with location and keys cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_update) begin
            r_state <= i_next;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

@@ src/pcids_step.sv @@
`default_nettype none

module pcids_step
    import pcids_pkg::*;
(
    input  wire t_search_state i_state,
    input  wire t_in_word      i_word,
    output t_search_state      o_state,
    output t_out_word          o_result
);

    logic [8:0] w_bus_inc;
    logic       w_last_slot;
    logic       w_absent;
    logic       w_match;
    logic       w_more_funcs;
    logic       w_emit;
    logic [7:0] w_offset;

    assign w_bus_inc    = {1'b0, i_state.cur_bus} + 9'd1;
    // Scan ends when the slot wraps off the last bus.
    assign w_last_slot  = (i_state.cur_slot == LAST_SLOT) && (w_bus_inc >= BUS_LIMIT);
    assign w_absent     = (i_word.read_data[15:0] == VENDOR_ABSENT);
    assign w_match      = (i_word.read_data[15:0] == i_state.want_vendor) &&
                          (i_word.read_data[31:16] == i_state.want_device);
    assign w_more_funcs = i_state.multi_function && (i_state.cur_function < LAST_FUNCTION);

    // Next state
    always_comb begin
        o_state = i_state;
        if (i_word.opcode == OP_START) begin
            o_state             = '0;
            o_state.want_vendor = i_word.vendor_key;
            o_state.want_device = i_word.device_key;
            o_state.phase       = PH_PROBE;
        end else begin
            case (i_state.phase)
                PH_PROBE: begin
                    if (w_absent) begin
                        o_state.cur_function   = '0;
                        o_state.multi_function = 1'b0;
                        o_state.phase          = PH_PROBE;
                        if (i_state.cur_slot == LAST_SLOT) begin
                            o_state.cur_slot = '0;
                            o_state.cur_bus  = w_bus_inc[7:0];
                            if (w_last_slot) begin
                                o_state.phase = PH_IDLE;
                            end
                        end else begin
                            o_state.cur_slot = i_state.cur_slot + 5'd1;
                        end
                    end else begin
                        o_state.phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    o_state.multi_function = i_word.read_data[23];
                    o_state.cur_function   = '0;
                    o_state.phase          = PH_FUNC_ID;
                end
                PH_FUNC_ID: begin
                    if (w_match) begin
                        o_state.phase = PH_CLASS;
                    end else if (w_more_funcs) begin
                        o_state.cur_function = i_state.cur_function + 3'd1;
                    end else begin
                        o_state.cur_function   = '0;
                        o_state.multi_function = 1'b0;
                        o_state.phase          = PH_PROBE;
                        if (i_state.cur_slot == LAST_SLOT) begin
                            o_state.cur_slot = '0;
                            o_state.cur_bus  = w_bus_inc[7:0];
                            if (w_last_slot) begin
                                o_state.phase = PH_IDLE;
                            end
                        end else begin
                            o_state.cur_slot = i_state.cur_slot + 5'd1;
                        end
                    end
                end
                PH_CLASS: begin
                    o_state.class_word = i_word.read_data;
                    o_state.phase      = PH_FOUND_HDR;
                end
                default: begin
                    o_state.phase = PH_IDLE;
                end
            endcase
        end
    end

    // Result word; request address is built from the updated location
    always_comb begin
        o_result = '0;
        w_emit   = 1'b1;
        w_offset = OFF_ID;
        if (i_word.opcode == OP_DATA) begin
            case (i_state.phase)
                PH_PROBE: begin
                    if (w_absent && w_last_slot) begin
                        w_emit        = 1'b0;
                        o_result.kind = KIND_NOT_FOUND;
                    end else if (!w_absent) begin
                        w_offset = OFF_HEADER;
                    end
                end
                PH_HEADER: begin
                    w_offset = OFF_ID;
                end
                PH_FUNC_ID: begin
                    if (w_match) begin
                        w_offset = OFF_CLASS;
                    end else if (!w_more_funcs && w_last_slot) begin
                        w_emit        = 1'b0;
                        o_result.kind = KIND_NOT_FOUND;
                    end
                end
                PH_CLASS: begin
                    w_offset = OFF_HEADER;
                end
                PH_FOUND_HDR: begin
                    w_emit                         = 1'b0;
                    o_result.kind                  = KIND_FOUND;
                    o_result.bus_number            = i_state.cur_bus;
                    o_result.slot_number           = i_state.cur_slot;
                    o_result.function_number       = i_state.cur_function;
                    o_result.base_class            = i_state.class_word[31:24];
                    o_result.subclass_code         = i_state.class_word[23:16];
                    o_result.programming_interface = i_state.class_word[15:8];
                    o_result.revision              = i_state.class_word[7:0];
                    o_result.header_kind           = i_word.read_data[23:16];
                end
                default: begin
                    w_emit        = 1'b0;
                    o_result.kind = KIND_IGNORED;
                end
            endcase
        end
        if (w_emit) begin
            o_result.kind            = KIND_REQUEST;
            o_result.request_address = {1'b1, 7'd0, o_state.cur_bus, o_state.cur_slot,
                                        o_state.cur_function,
                                        w_offset[7:2] & OFF_DWORD_MASK[7:2], 2'b00};
        end
    end

endmodule

`default_nettype wire
